// ===== hdl/qsd_pkg.sv =====
// ----------------------------------------------------------------------------
// qsd_pkg
// Types and constants shared by the quadrature step decoder modules.
// ----------------------------------------------------------------------------
package qsd_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned PHASE_W   = 4;
   localparam int unsigned LOCKOUT_W = 20;
   localparam int unsigned CSR_W     = 32;
   localparam int unsigned CSR_AW    = 3;

   typedef logic        [TIME_W-1:0]    time_type;
   typedef logic signed [COUNT_W-1:0]   count_type;
   typedef logic signed [PHASE_W-1:0]   phase_type;
   // one bit wider than phase_type; holds a full step of +4 / -4
   typedef logic signed [PHASE_W:0]     phase_wide_type;
   typedef logic        [LOCKOUT_W-1:0] lockout_type;

   // register word index (paddr[2]) of the lockout register
   localparam logic REG_LOCKOUT = 1'b0;

   // channel codes
   localparam logic CHAN_A = 1'b0;
   localparam logic CHAN_B = 1'b1;

   localparam phase_wide_type PHASE_FULL_FWD = 5'sd4;
   localparam phase_wide_type PHASE_FULL_REV = -5'sd4;

   typedef struct packed {
      count_type position;
      logic      accepted;
      phase_type phase_now;
   } result_type;

endpackage

// ===== hdl/qsd_csr.sv =====
// ----------------------------------------------------------------------------
// qsd_csr
// APB-style register port holding the debounce lockout time.
// ----------------------------------------------------------------------------
module qsd_csr
   import qsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]  csr_prdata,
   output logic              csr_pready,
   output lockout_type       lockout
);

   lockout_type lockout_ff, lockout_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_LOCKOUT);

   always_comb begin
      lockout_in = lockout_ff;
      if (wr_en) begin
         lockout_in = csr_pwdata[LOCKOUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= '0;
      end else begin
         lockout_ff <= lockout_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_LOCKOUT) begin
         csr_prdata = {{(CSR_W-LOCKOUT_W){1'b0}}, lockout_ff};
      end
   end

   assign lockout = lockout_ff;

endmodule

// ===== hdl/qsd_step.sv =====
// ----------------------------------------------------------------------------
// qsd_step
// Decoder state (phase, last transition time, detent count) and the
// single-pass next-state logic for one pin-change event.
// ----------------------------------------------------------------------------
module qsd_step
   import qsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  lockout_type lockout,
   input  logic        evt_fire,
   input  logic        evt_opcode,
   input  logic        evt_level_a,
   input  logic        evt_level_b,
   input  time_type    evt_time_us,
   output result_type  result
);

   phase_type      phase_ff, phase_in;
   time_type       last_ff, last_in;
   count_type      count_ff, count_in;

   time_type       elapsed;
   logic           in_window;
   logic           step_up, step_dn;
   phase_wide_type phase_w, phase_step;
   logic           full_fwd, full_rev;

   assign elapsed   = evt_time_us - last_ff;
   assign in_window = elapsed >= {{(TIME_W-LOCKOUT_W){1'b0}}, lockout};
   assign phase_w   = {phase_ff[PHASE_W-1], phase_ff};

   // transition table per channel; up and down rules never both match
   always_comb begin
      step_up = 1'b0;
      step_dn = 1'b0;
      unique case (evt_opcode)
         CHAN_A: begin
            step_up = (phase_ff == 4'sd0  && !evt_level_a &&  evt_level_b) ||
                      (phase_ff == 4'sd2  &&  evt_level_a && !evt_level_b);
            step_dn = (phase_ff == -4'sd1 && !evt_level_a && !evt_level_b) ||
                      (phase_ff == -4'sd3 &&  evt_level_a &&  evt_level_b);
         end
         CHAN_B: begin
            step_up = (phase_ff == 4'sd1  && !evt_level_a && !evt_level_b) ||
                      (phase_ff == 4'sd3  &&  evt_level_a &&  evt_level_b);
            step_dn = (phase_ff == 4'sd0  &&  evt_level_a && !evt_level_b) ||
                      (phase_ff == -4'sd2 && !evt_level_a &&  evt_level_b);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      phase_step = phase_w;
      if (step_up) begin
         phase_step = phase_w + 5'sd1;
      end else if (step_dn) begin
         phase_step = phase_w - 5'sd1;
      end
   end

   assign full_fwd = phase_step == PHASE_FULL_FWD;
   assign full_rev = phase_step == PHASE_FULL_REV;

   always_comb begin
      phase_in = phase_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (in_window) begin
         phase_in = phase_step[PHASE_W-1:0];
         if (step_up || step_dn) begin
            last_in = evt_time_us;
         end
         if (full_fwd) begin
            count_in = count_ff + 32'sd1;
         end else if (full_rev) begin
            count_in = count_ff - 32'sd1;
         end
         if (evt_level_a && evt_level_b) begin
            phase_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         last_ff  <= '0;
         count_ff <= '0;
      end else if (evt_fire) begin
         phase_ff <= phase_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   assign result.position  = count_in;
   assign result.accepted  = in_window;
   assign result.phase_now = phase_in;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff >= -4'sd3) && (phase_ff <= 4'sd3))
      else $error("phase left the -3..3 range");

   a_locked_holds: assert property (@(posedge clock) disable iff (reset)
      (evt_fire && !in_window) |=> ($stable(count_ff) && $stable(phase_ff) && $stable(last_ff)))
      else $error("locked-out event changed decoder state");

   a_both_high_clears: assert property (@(posedge clock) disable iff (reset)
      (evt_fire && in_window && evt_level_a && evt_level_b) |=> (phase_ff == 4'sd0))
      else $error("phase not cleared with both pins high");

endmodule

// ===== hdl/quadrature_step_decoder.sv =====
// ----------------------------------------------------------------------------
// quadrature_step_decoder
// Quadrature encoder decoder with a debounce lockout: one pin-change
// request in, one position/phase result out.
// ----------------------------------------------------------------------------
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   opcode, level_a, level_b, time_us
//   rsp      out        rsp_valid / rsp_stall   position, accepted, phase_now
//   csr      in         APB psel/penable/pready lockout_us at byte address 0
//
// One request per cycle while req_stall is low; a request passes the input
// register, then the result register. The decoder state is written in the
// same edge as the result, so the phase loop through qsd_step sets that rate.
// Reset is synchronous and clears the state, the lockout and both valids.
// A stalled result holds; the input register takes a request while it is
// empty or the result register is empty or being taken, else req_stall rises.
// ----------------------------------------------------------------------------
module quadrature_step_decoder
   import qsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic              req_level_a,
   input  logic              req_level_b,
   input  logic [31:0]       req_time_us,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [31:0] rsp_position,
   output logic              rsp_accepted,
   output logic signed [3:0] rsp_phase_now,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   lockout_type lockout;
   result_type  step_res;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_opcode_ff, s1_level_a_ff, s1_level_b_ff;
   time_type   s1_time_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff;
   logic       advance;
   logic       req_take;

   qsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .lockout     (lockout)
   );

   // result register free this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   qsd_step u_step (
      .clock       (clock),
      .reset       (reset),
      .lockout     (lockout),
      .evt_fire    (s1_valid_ff && advance),
      .evt_opcode  (s1_opcode_ff),
      .evt_level_a (s1_level_a_ff),
      .evt_level_b (s1_level_b_ff),
      .evt_time_us (s1_time_ff),
      .result      (step_res)
   );

   always_comb begin
      // an empty input register fills even while the result is stalled
      s1_valid_in = req_take || (s1_valid_ff && !advance);
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff  <= req_opcode;
         s1_level_a_ff <= req_level_a;
         s1_level_b_ff <= req_level_b;
         s1_time_ff    <= req_time_us;
      end
      if (advance && s1_valid_ff) begin
         rsp_res_ff <= step_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_res_ff.position;
   assign rsp_accepted  = rsp_res_ff.accepted;
   assign rsp_phase_now = rsp_res_ff.phase_now;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with no item blocking");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance) |=> rsp_valid_ff)
      else $error("evaluated request produced no result");

   a_taken_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !s1_valid_ff) |=> !rsp_valid_ff)
      else $error("result repeated after it was taken");

endmodule
